[hdl/rpfa_pkg.sv]
// shared types and constants of the page frame allocator
`timescale 1ns / 1ps
`default_nettype none

package rpfa_pkg;

    // fixed field widths
    localparam int ADDR_W      = 32;
    localparam int LOW_PAGE_W  = 16;
    localparam int TOP_PAGE_W  = 17;
    localparam int CFG_DATA_W  = 17;
    localparam int REF_OUT_W   = 8;
    localparam int CMP_W       = 33;

    localparam logic [TOP_PAGE_W-1:0] TOP_PAGE_RESET = 17'h10000;

    // configuration register indexes
    localparam logic CFG_LOW_PAGE = 1'b0;
    localparam logic CFG_TOP_PAGE = 1'b1;

    // command codes
    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_ADDREF = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_PAGE  = 2'd1,
        STAT_BAD_ADDR = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    // classified command passed from front to back
    typedef struct packed {
        cmd_t cmd;
        logic bad;
    } op_t;

    // back end status seen by the front end
    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

`default_nettype wire

[hdl/refcounted_page_frame_allocator_unit.sv]
// top level of the reference counted page frame allocator
//
// channel  direction  handshake             payload
// cfg      in         cfg_we                cfg_index, cfg_wdata
// in       in         in_valid / in_stall   cmd, phys_addr
// out      out        out_valid / out_stall status, page_addr, ref_count, returned_to_pool
//
// in the back sequencer each item has a read step, which reads the count and
// stack memories, then an update step, which updates them and loads the result register
// after reset a sweep clears the count memory, with in_stall high
// a two-entry queue holds classified items while the back end or out_stall holds
// items are issued only when the result register will be free in the update cycle
`timescale 1ns / 1ps
`default_nettype none

module refcounted_page_frame_allocator_unit #(
    parameter int PAGE_BITS  = 12,
    parameter int NUM_PAGES  = 65536,
    parameter int COUNT_BITS = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic                                 cfg_index,
    input  wire logic [rpfa_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [1:0]                           cmd,
    input  wire logic [rpfa_pkg::ADDR_W-1:0]          phys_addr,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [1:0]                                status,
    output logic [rpfa_pkg::ADDR_W-1:0]               page_addr,
    output logic [rpfa_pkg::REF_OUT_W-1:0]            ref_count,
    output logic                                      returned_to_pool
);

    localparam int PN_W = $clog2(NUM_PAGES);
    localparam int DW   = $clog2(NUM_PAGES + 1);

    logic                   q_valid;
    logic                   q_pop;
    rpfa_pkg::op_t          q_op;
    logic [PN_W-1:0]        q_page;
    rpfa_pkg::back_status_t bstat;

    // item intake and classification
    rpfa_front #(
        .PAGE_BITS (PAGE_BITS),
        .NUM_PAGES (NUM_PAGES),
        .PN_W      (PN_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .phys_addr (phys_addr),
        .bstat     (bstat),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_op      (q_op),
        .q_page    (q_page)
    );

    // memory update and results
    rpfa_back #(
        .PAGE_BITS  (PAGE_BITS),
        .NUM_PAGES  (NUM_PAGES),
        .COUNT_BITS (COUNT_BITS),
        .PN_W       (PN_W),
        .DW         (DW)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_op             (q_op),
        .q_page           (q_page),
        .bstat            (bstat),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .page_addr        (page_addr),
        .ref_count        (ref_count),
        .returned_to_pool (returned_to_pool)
    );

    // no item enters while the count memory is being cleared
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.clearing |-> in_stall)
        else $error("item intake open during clear sweep");

    // a page goes back to the pool only with a zero count and ok status
    a_push_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && returned_to_pool) |->
            (status == rpfa_pkg::STAT_OK && ref_count == '0 && page_addr == '0))
        else $error("page returned with nonzero count or bad status");

    // a failed alloc carries no page and no count
    a_no_page: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == rpfa_pkg::STAT_NO_PAGE) |->
            (page_addr == '0 && ref_count == '0))
        else $error("failed alloc returned a page");

    // the back end never pops from an empty queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_valid && !bstat.clearing))
        else $error("pop from empty queue");

endmodule

`default_nettype wire

[hdl/rpfa_front.sv]
// front end: config registers, address check and two-entry command queue
`timescale 1ns / 1ps
`default_nettype none

module rpfa_front #(
    parameter int PAGE_BITS = 12,
    parameter int NUM_PAGES = 65536,
    parameter int PN_W      = $clog2(NUM_PAGES)
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic                                 cfg_index,
    input  wire logic [rpfa_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [1:0]                           cmd,
    input  wire logic [rpfa_pkg::ADDR_W-1:0]          phys_addr,
    input  wire rpfa_pkg::back_status_t               bstat,
    output logic                                      q_valid,
    input  wire logic                                 q_pop,
    output rpfa_pkg::op_t                             q_op,
    output logic [PN_W-1:0]                           q_page
);

    logic [rpfa_pkg::LOW_PAGE_W-1:0] low_page_reg;
    logic [rpfa_pkg::TOP_PAGE_W-1:0] top_page_reg;

    rpfa_pkg::op_t       op_reg   [2];
    logic [PN_W-1:0]     page_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;

    logic [rpfa_pkg::CMP_W-1:0] pg;
    logic                       addr_ok;
    rpfa_pkg::op_t              new_op;
    logic                       push;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_page_reg <= '0;
            top_page_reg <= rpfa_pkg::TOP_PAGE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rpfa_pkg::CFG_LOW_PAGE: low_page_reg <= cfg_wdata[rpfa_pkg::LOW_PAGE_W-1:0];
                rpfa_pkg::CFG_TOP_PAGE: top_page_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // address check: page aligned and inside the usable window
    always_comb
    begin
        pg = rpfa_pkg::CMP_W'(phys_addr >> PAGE_BITS);
        addr_ok = (phys_addr[PAGE_BITS-1:0] == '0)
               && (pg >= rpfa_pkg::CMP_W'(low_page_reg))
               && (pg <  rpfa_pkg::CMP_W'(top_page_reg))
               && (pg <  rpfa_pkg::CMP_W'(NUM_PAGES));
        new_op.cmd = rpfa_pkg::cmd_t'(cmd);
        case (new_op.cmd)
            rpfa_pkg::CMD_ALLOC: new_op.bad = 1'b0;
            default:             new_op.bad = !addr_ok;
        endcase
    end

    // queue handshake
    assign in_stall = (count_reg == 2'd2) || bstat.clearing;
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_op     = op_reg[rd_ptr_reg];
    assign q_page   = page_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_reg[wr_ptr_reg]   <= new_op;
            page_reg[wr_ptr_reg] <= pg[PN_W-1:0];
        end
    end

endmodule

`default_nettype wire

[hdl/rpfa_back.sv]
// back end: count and free stack memories, command sequencer, result register
`timescale 1ns / 1ps
`default_nettype none

module rpfa_back #(
    parameter int PAGE_BITS  = 12,
    parameter int NUM_PAGES  = 65536,
    parameter int COUNT_BITS = 8,
    parameter int PN_W       = $clog2(NUM_PAGES),
    parameter int DW         = $clog2(NUM_PAGES + 1)
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 q_valid,
    output logic                                      q_pop,
    input  wire rpfa_pkg::op_t                        q_op,
    input  wire logic [PN_W-1:0]                      q_page,
    output rpfa_pkg::back_status_t                    bstat,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [1:0]                                status,
    output logic [rpfa_pkg::ADDR_W-1:0]               page_addr,
    output logic [rpfa_pkg::REF_OUT_W-1:0]            ref_count,
    output logic                                      returned_to_pool
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    // memories
    logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
    logic [PN_W-1:0]       stk_mem [NUM_PAGES];

    logic                  cnt_we;
    logic [PN_W-1:0]       cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [PN_W-1:0]       cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic                  stk_we;
    logic [PN_W-1:0]       stk_waddr;
    logic [PN_W-1:0]       stk_raddr;
    logic [PN_W-1:0]       stk_rdata;

    // control and result registers
    state_t                           state_reg, state_next;
    logic [PN_W-1:0]                  clr_idx_reg, clr_idx_next;
    logic [DW-1:0]                    depth_reg, depth_next;
    rpfa_pkg::op_t                    op_reg, op_next;
    logic [PN_W-1:0]                  page_reg, page_next;
    logic                             out_valid_reg, out_valid_next;
    logic [1:0]                       status_reg, status_next;
    logic [rpfa_pkg::ADDR_W-1:0]      page_addr_reg, page_addr_next;
    logic [rpfa_pkg::REF_OUT_W-1:0]   ref_count_reg, ref_count_next;
    logic                             pushed_reg, pushed_next;

    logic [COUNT_BITS-1:0] dec_cnt;
    logic [COUNT_BITS-1:0] inc_cnt;
    logic                  stack_full;

    assign cnt_raddr = q_page;
    assign stk_raddr = PN_W'(depth_reg - 1'b1);
    assign stk_waddr = depth_reg[PN_W-1:0];

    // count memory, cleared by the sweep after reset
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata <= cnt_mem[cnt_raddr];
    end

    // free stack memory
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= page_reg;
        end
        stk_rdata <= stk_mem[stk_raddr];
    end

    // sequencer: clear sweep, then a read step and an update step per item
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        depth_next     = depth_reg;
        op_next        = op_reg;
        page_next      = page_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        page_addr_next = page_addr_reg;
        ref_count_next = ref_count_reg;
        pushed_next    = pushed_reg;
        q_pop          = 1'b0;
        cnt_we         = 1'b0;
        cnt_waddr      = page_reg;
        cnt_wdata      = '0;
        stk_we         = 1'b0;

        dec_cnt    = (cnt_rdata != '0) ? cnt_rdata - COUNT_BITS'(1) : '0;
        inc_cnt    = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + COUNT_BITS'(1);
        stack_full = (depth_reg >= DW'(NUM_PAGES));

        case (state_reg)
            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_idx_reg;
                if (clr_idx_reg == PN_W'(NUM_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (q_valid && (!out_valid_reg || !out_stall))
                begin
                    q_pop      = 1'b1;
                    op_next    = q_op;
                    page_next  = q_page;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                status_next    = rpfa_pkg::STAT_OK;
                page_addr_next = '0;
                ref_count_next = '0;
                pushed_next    = 1'b0;
                if (op_reg.cmd == rpfa_pkg::CMD_ALLOC)
                begin
                    if (depth_reg == '0)
                    begin
                        status_next = rpfa_pkg::STAT_NO_PAGE;
                    end
                    else
                    begin
                        depth_next     = depth_reg - 1'b1;
                        cnt_we         = 1'b1;
                        cnt_waddr      = stk_rdata;
                        cnt_wdata      = COUNT_BITS'(1);
                        ref_count_next = rpfa_pkg::REF_OUT_W'(1);
                        page_addr_next = rpfa_pkg::ADDR_W'({stk_rdata, {PAGE_BITS{1'b0}}});
                    end
                end
                else if (op_reg.bad)
                begin
                    status_next = rpfa_pkg::STAT_BAD_ADDR;
                end
                else
                begin
                    case (op_reg.cmd)
                        rpfa_pkg::CMD_FREE:
                        begin
                            if ((dec_cnt == '0) && stack_full)
                            begin
                                status_next    = rpfa_pkg::STAT_FULL;
                                ref_count_next = rpfa_pkg::REF_OUT_W'(cnt_rdata);
                            end
                            else
                            begin
                                cnt_we         = 1'b1;
                                cnt_wdata      = dec_cnt;
                                ref_count_next = rpfa_pkg::REF_OUT_W'(dec_cnt);
                                if (dec_cnt == '0)
                                begin
                                    stk_we      = 1'b1;
                                    depth_next  = depth_reg + 1'b1;
                                    pushed_next = 1'b1;
                                end
                            end
                        end
                        rpfa_pkg::CMD_ADDREF:
                        begin
                            cnt_we         = 1'b1;
                            cnt_wdata      = inc_cnt;
                            ref_count_next = rpfa_pkg::REF_OUT_W'(inc_cnt);
                        end
                        default:
                        begin
                            ref_count_next = rpfa_pkg::REF_OUT_W'(cnt_rdata);
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= '0;
            page_reg      <= '0;
            status_reg    <= rpfa_pkg::STAT_OK;
            page_addr_reg <= '0;
            ref_count_reg <= '0;
            pushed_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
            page_reg      <= page_next;
            status_reg    <= status_next;
            page_addr_reg <= page_addr_next;
            ref_count_reg <= ref_count_next;
            pushed_reg    <= pushed_next;
        end
    end

    assign bstat.clearing   = (state_reg == S_CLEAR);
    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign page_addr        = page_addr_reg;
    assign ref_count        = ref_count_reg;
    assign returned_to_pool = pushed_reg;

endmodule

`default_nettype wire

[tb/tb_refcounted_page_frame_allocator_unit.sv]
// self-checking testbench for the reference counted page frame allocator
`timescale 1ns / 1ps

module tb_refcounted_page_frame_allocator_unit;

    localparam int PAGE_SHIFT = 12;
    localparam int FRAMES     = 65536;
    localparam int CNT_BITS   = 8;

    // one expected result item
    typedef struct {
        rpfa_pkg::status_t st;
        logic [31:0]       pa;
        logic [7:0]        rc;
        logic              back;
    } frame_result_t;

    // allocator state mirror and queue of expected result items
    class page_ledger;
        logic [7:0]    counts [FRAMES];
        logic [15:0]   stack [FRAMES];
        int unsigned   depth;
        logic [15:0]   low_pg;
        logic [16:0]   top_pg;
        frame_result_t expected_q [$];
        int            errors;

        function new();
            foreach (counts[i]) counts[i] = '0;
            depth  = 0;
            low_pg = '0;
            top_pg = rpfa_pkg::TOP_PAGE_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [16:0] v);
            if (idx == rpfa_pkg::CFG_LOW_PAGE) low_pg = v[15:0];
            else top_pg = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // work out the result of one accepted item and update the mirror
        function void note_command(rpfa_pkg::cmd_t c, logic [31:0] a);
            frame_result_t r;
            logic [19:0]   pg;
            logic [15:0]   p;
            logic          ok;
            logic [7:0]    cur;
            logic [7:0]    nxt;
            r.st   = rpfa_pkg::STAT_OK;
            r.pa   = '0;
            r.rc   = '0;
            r.back = 1'b0;
            pg = a[31:PAGE_SHIFT];
            p  = pg[15:0];
            ok = (a[PAGE_SHIFT-1:0] == '0) && (pg >= low_pg) && (pg < top_pg)
                 && (pg < 20'h10000);
            if (c == rpfa_pkg::CMD_ALLOC) begin
                if (depth == 0) begin
                    r.st = rpfa_pkg::STAT_NO_PAGE;
                end
                else begin
                    depth--;
                    p = stack[depth];
                    counts[p] = 8'd1;
                    r.rc = 8'd1;
                    r.pa = {4'h0, p, 12'h000};
                end
            end
            else if (!ok) begin
                r.st = rpfa_pkg::STAT_BAD_ADDR;
            end
            else if (c == rpfa_pkg::CMD_FREE) begin
                cur = counts[p];
                nxt = (cur != 0) ? cur - 8'd1 : 8'd0;
                if (nxt == 0 && depth >= FRAMES) begin
                    // stack full, the free is dropped
                    r.st = rpfa_pkg::STAT_FULL;
                    r.rc = cur;
                end
                else begin
                    counts[p] = nxt;
                    r.rc = nxt;
                    if (nxt == 0) begin
                        stack[depth] = p;
                        depth++;
                        r.back = 1'b1;
                    end
                end
            end
            else if (c == rpfa_pkg::CMD_ADDREF) begin
                if (counts[p] != {CNT_BITS{1'b1}}) counts[p] = counts[p] + 8'd1;
                r.rc = counts[p];
            end
            else begin
                r.rc = counts[p];
            end
            expected_q.push_back(r);
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 100)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, what, want, got);
        endfunction

        // compare one result item with the oldest expectation
        function void check_result(logic [1:0] got_st, logic [31:0] got_pa,
                                   logic [7:0] got_rc, logic got_back);
            frame_result_t e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 100)
                    $display("%0t: result item with none expected, %s %0d %0h %0d %0d",
                             $time, "expected nothing, got", got_st, got_pa, got_rc,
                             got_back);
            end
            else begin
                e = expected_q.pop_front();
                if (got_st !== e.st) flag("status", e.st, got_st);
                if (got_pa !== e.pa) flag("page_addr", e.pa, got_pa);
                if (got_rc !== e.rc) flag("ref_count", e.rc, got_rc);
                if (got_back !== e.back) flag("returned_to_pool", e.back, got_back);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [16:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [31:0] phys_addr;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] page_addr;
    logic [7:0]  ref_count;
    logic        returned_to_pool;

    page_ledger ledger;
    bit         idle_on;
    int         hold_left;
    int         win_lo;
    int         win_hi;

    refcounted_page_frame_allocator_unit #(
        .PAGE_BITS  (PAGE_SHIFT),
        .NUM_PAGES  (FRAMES),
        .COUNT_BITS (CNT_BITS)
    ) dut (.*);

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog
    initial
    begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: check accepted items, stall at random or for a long hold
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                ledger.check_result(status, page_addr, ref_count, returned_to_pool);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else
            begin
                out_stall <= idle_on && ($urandom_range(99) < 35);
            end
        end
    end

    // offer one item, hold it until accepted, then note it
    task automatic send_item(rpfa_pkg::cmd_t c, logic [31:0] a);
        while (idle_on && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        phys_addr <= a;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        ledger.note_command(c, a);
    endtask

    // stop offering and wait until every result item is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (ledger.pending() != 0);
        repeat (6) @(posedge clk);
    endtask

    // write both page limits while the block is idle
    task automatic set_window(logic [16:0] lo, logic [16:0] hi);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= rpfa_pkg::CFG_LOW_PAGE;
        cfg_wdata <= lo;
        @(posedge clk);
        ledger.write_reg(rpfa_pkg::CFG_LOW_PAGE, lo);
        cfg_index <= rpfa_pkg::CFG_TOP_PAGE;
        cfg_wdata <= hi;
        @(posedge clk);
        ledger.write_reg(rpfa_pkg::CFG_TOP_PAGE, hi);
        cfg_we <= 1'b0;
        win_lo = lo[15:0];
        win_hi = (hi > 17'h10000) ? FRAMES : int'(hi);
    endtask

    // mostly valid pages of the window, the rest bad addresses of every kind
    function automatic logic [31:0] pick_addr(int noise_pct);
        int unsigned pg;
        int unsigned r;
        pg = 0;
        if (win_hi > win_lo) pg = $urandom_range(win_hi - 1, win_lo);
        r = $urandom_range(99);
        if (win_hi > win_lo && r >= noise_pct) return pg << PAGE_SHIFT;
        case ($urandom_range(4))
            0: return $urandom();
            1: return (win_hi > win_lo) ? ((pg << PAGE_SHIFT) | $urandom_range(4095, 1))
                                        : $urandom();
            2: return (win_lo > 0) ? ($urandom_range(win_lo - 1, 0) << PAGE_SHIFT)
                                   : ($urandom() | 32'h1);
            3: return $urandom_range(32'hFFFFF, win_hi) << PAGE_SHIFT;
            default: return $urandom() & 32'hFFFFF000;
        endcase
    endfunction

    task automatic run_random(int n, int w_alloc, int w_free, int w_addref, int noise_pct);
        int             r;
        rpfa_pkg::cmd_t c;
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < w_alloc) c = rpfa_pkg::CMD_ALLOC;
            else if (r < w_alloc + w_free) c = rpfa_pkg::CMD_FREE;
            else if (r < w_alloc + w_free + w_addref) c = rpfa_pkg::CMD_ADDREF;
            else c = rpfa_pkg::CMD_READ;
            send_item(c, (c == rpfa_pkg::CMD_ALLOC) ? $urandom() : pick_addr(noise_pct));
        end
    endtask

    // stimulus
    initial
    begin
        ledger    = new();
        idle_on   = 1'b1;
        hold_left = 0;
        win_lo    = 0;
        win_hi    = FRAMES;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = rpfa_pkg::CFG_LOW_PAGE;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        cmd       = rpfa_pkg::CMD_ALLOC;
        phys_addr = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty pool, pushes, double push, address checks
        set_window(17'h10, 17'h20);
        send_item(rpfa_pkg::CMD_ALLOC, $urandom());
        send_item(rpfa_pkg::CMD_FREE, 32'h0001_0000);
        send_item(rpfa_pkg::CMD_FREE, 32'h0001_1000);
        send_item(rpfa_pkg::CMD_ALLOC, $urandom());
        send_item(rpfa_pkg::CMD_ADDREF, 32'h0001_1000);
        send_item(rpfa_pkg::CMD_READ, 32'h0001_1000);
        send_item(rpfa_pkg::CMD_FREE, 32'h0001_1000);
        send_item(rpfa_pkg::CMD_FREE, 32'h0001_1000);
        send_item(rpfa_pkg::CMD_FREE, 32'h0001_1000);
        send_item(rpfa_pkg::CMD_READ, 32'h0000_F000);
        send_item(rpfa_pkg::CMD_READ, 32'h0002_0000);
        send_item(rpfa_pkg::CMD_ADDREF, 32'h0001_F000);
        send_item(rpfa_pkg::CMD_FREE, 32'h0001_0800);
        send_item(rpfa_pkg::CMD_ADDREF, 32'h0001_0001);
        send_item(rpfa_pkg::CMD_READ, 32'hFFFF_F000);
        send_item(rpfa_pkg::CMD_FREE, 32'h0000_0000);
        repeat (4) send_item(rpfa_pkg::CMD_ALLOC, $urandom());

        // highest page only; bit 16 of the low page write is dropped
        set_window(17'h1FFFF, 17'h10000);
        send_item(rpfa_pkg::CMD_ADDREF, 32'h0FFF_F000);
        send_item(rpfa_pkg::CMD_FREE, 32'h0FFF_F000);
        send_item(rpfa_pkg::CMD_ALLOC, $urandom());
        send_item(rpfa_pkg::CMD_READ, 32'h0FFF_E000);

        // empty window
        set_window(17'h0, 17'h0);
        send_item(rpfa_pkg::CMD_READ, 32'h0000_0000);
        send_item(rpfa_pkg::CMD_FREE, 32'h0000_0000);

        // back to back pushes and counts, then drain the pool past empty
        set_window(17'h0, 17'h10000);
        idle_on = 1'b0;
        send_item(rpfa_pkg::CMD_FREE, 32'h0000_5000);
        send_item(rpfa_pkg::CMD_FREE, 32'h0000_5000);
        send_item(rpfa_pkg::CMD_ADDREF, 32'h0000_6000);
        send_item(rpfa_pkg::CMD_ADDREF, 32'h0000_6000);
        send_item(rpfa_pkg::CMD_FREE, 32'h0000_6000);
        send_item(rpfa_pkg::CMD_FREE, 32'h0000_6000);
        send_item(rpfa_pkg::CMD_READ, 32'h0000_6000);
        while (ledger.depth > 0) send_item(rpfa_pkg::CMD_ALLOC, $urandom());
        send_item(rpfa_pkg::CMD_ALLOC, $urandom());
        send_item(rpfa_pkg::CMD_FREE, 32'h0000_6000);
        idle_on = 1'b1;

        // one hot page: climb to saturation, then free down to zero
        set_window(17'h40, 17'h41);
        run_random(400, 0, 8, 80, 5);
        run_random(300, 0, 85, 5, 5);

        // main mix with a long receiver hold-off
        set_window(17'h1_0100, 17'h140);
        hold_left = 300;
        run_random(350, 25, 30, 25, 22);
        wait_drained();
        run_random(300, 25, 30, 25, 22);
        idle_on = 1'b0;
        run_random(150, 25, 30, 25, 22);
        idle_on = 1'b1;

        // whole page range and the window extremes
        set_window(17'h0, 17'h10000);
        run_random(120, 25, 30, 25, 22);
        set_window(17'hFFFF, 17'h10000);
        run_random(30, 25, 30, 25, 22);
        set_window(17'h20, 17'h10);
        run_random(15, 25, 30, 25, 22);

        wait_drained();
        repeat (10) @(posedge clk);
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
